>>> src/lar_pkg.sv
`default_nettype none

package lar_pkg;

    localparam int IN_SAMPLES = 304;
    localparam int IDX_W      = $clog2(IN_SAMPLES);

    localparam int SIDX_W = 9;
    localparam int SVAL_W = 8;
    localparam int OIDX_W = 12;
    localparam int CFG_W  = 13;
    localparam int DIV_W  = 13;
    localparam int OUT_W  = 16;
    localparam int FRAC_W = 8;

    localparam int PROD_W = OIDX_W + IDX_W;
    localparam int NUM_W  = PROD_W + FRAC_W;
    localparam int QW     = $clog2((IN_SAMPLES - 1) * 256 + 1);
    localparam int HI_W   = NUM_W - QW;
    localparam int DV_STAGES = QW + 1;

    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(734);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(IN_SAMPLES - 1);
    localparam logic signed [8:0] GAIN     = 9'sd200;
    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_OUTPUT = 1'b1;

    typedef struct packed {
        logic              req;
        logic [SIDX_W-1:0] sidx;
        logic [SVAL_W-1:0] sval;
        logic [OIDX_W-1:0] oidx;
        logic              sat;
        logic [DIV_W-1:0]  rem;
        logic [QW-1:0]     q;
        logic [QW-1:0]     nlo;
    } t_dv;

endpackage

`default_nettype wire

>>> src/linear_audio_resampler_top.sv
// linear audio resampler
//
// input channel (i_in_valid / o_in_ready): each item is either a load, which
// writes i_sample_value into the frame at i_sample_index, or an output
// request, which returns one interpolated sample for i_out_index.
// output channel (o_out_valid / i_out_ready): one result per request, in
// request order, carrying the scaled sample and an echo of the index.
// config channel (i_cfg_valid / o_cfg_ready): writes out_count; always ready.
//
// a new item is taken every cycle while o_in_ready is high. a request's
// result is built by input capture, position multiply, range check,
// one restoring divider step per stage for the 17 quotient bits, frame
// read, interpolation and gain. results wait in a 32 entry output queue;
// o_in_ready drops only when 32 requests are in flight or queued, so a
// stalled receiver backs up into the input without losing anything.
// reset empties the pipeline and queue and sets out_count to 735; the frame
// memory is not cleared and must be loaded before it is read.
`default_nettype none

module linear_audio_resampler_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic        [lar_pkg::SIDX_W-1:0]   i_sample_index,
    input  logic signed [lar_pkg::SVAL_W-1:0]   i_sample_value,
    input  logic        [lar_pkg::OIDX_W-1:0]   i_out_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lar_pkg::OUT_W-1:0]    o_out_sample,
    output logic        [lar_pkg::OIDX_W-1:0]   o_out_position,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [lar_pkg::CFG_W-1:0]    i_cfg_data
);
    import lar_pkg::*;

    function automatic t_dv dv_step(input t_dv s, input logic [DIV_W-1:0] d);
        t_dv              res;
        logic [DIV_W:0]   rem2;
        logic             ge;
        begin
            res      = s;
            rem2     = {s.rem, s.nlo[QW-1]};
            ge       = (rem2 >= {1'b0, d});
            res.rem  = ge ? DIV_W'(rem2 - {1'b0, d}) : DIV_W'(rem2);
            res.q    = {s.q[QW-2:0], ge};
            res.nlo  = {s.nlo[QW-2:0], 1'b0};
            return res;
        end
    endfunction

    logic                  w_in_acc;
    logic                  w_req_acc;
    logic                  w_out_acc;

    logic [DIV_W-1:0]      r_div;
    logic [DIV_W-1:0]      n_div;

    logic                  r_s1_vld;
    logic                  r_s1_req;
    logic [SIDX_W-1:0]     r_s1_sidx;
    logic [SVAL_W-1:0]     r_s1_sval;
    logic [OIDX_W-1:0]     r_s1_oidx;

    logic                  r_s2_vld;
    logic                  r_s2_req;
    logic [SIDX_W-1:0]     r_s2_sidx;
    logic [SVAL_W-1:0]     r_s2_sval;
    logic [OIDX_W-1:0]     r_s2_oidx;
    logic [PROD_W-1:0]     r_s2_prod;
    logic [PROD_W-1:0]     n_s2_prod;

    logic [NUM_W-1:0]      w_num;
    logic [HI_W-1:0]       w_hi;
    logic                  w_sat;

    logic                  r_dv_vld [DV_STAGES];
    t_dv                   r_dv     [DV_STAGES];
    t_dv                   n_dv     [DV_STAGES];

    t_dv                   w_m;
    logic [QW-FRAC_W-1:0]  w_qint;
    logic                  w_clamp;
    logic [IDX_W-1:0]      w_idx;
    logic [IDX_W-1:0]      w_nidx;
    logic [FRAC_W-1:0]     w_frac;
    logic                  w_wr;
    logic [IDX_W-1:0]      w_waddr;

    logic [SVAL_W-1:0]     r_frame [IN_SAMPLES];

    logic                  r_m_vld;
    logic [SVAL_W-1:0]     r_m_s0;
    logic [SVAL_W-1:0]     r_m_s1;
    logic [FRAC_W-1:0]     r_m_frac;
    logic [OIDX_W-1:0]     r_m_oidx;

    logic signed [8:0]     w_diff;
    logic signed [17:0]    w_prod;

    logic                  r_i_vld;
    logic [SVAL_W-1:0]     r_i_s0;
    logic [9:0]            r_i_term;
    logic [OIDX_W-1:0]     r_i_oidx;

    logic signed [10:0]    w_mixed;
    logic signed [19:0]    w_scaled;
    logic [OUT_W-1:0]      w_sample;

    logic [OUT_W-1:0]      r_fifo_smp [FIFO_DEPTH];
    logic [OIDX_W-1:0]     r_fifo_pos [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]      r_fifo_cnt;
    logic [CNT_W-1:0]      n_fifo_cnt;
    logic [CNT_W-1:0]      r_credit;
    logic [CNT_W-1:0]      n_credit;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_credit != CNT_W'(FIFO_DEPTH));
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_req_acc   = w_in_acc & (i_req_type == REQ_OUTPUT);
    assign w_out_acc   = o_out_valid & i_out_ready;

    // divisor from out_count
    always_comb begin
        if (i_cfg_data > CFG_W'(1)) begin
            n_div = DIV_W'(i_cfg_data - CFG_W'(1));
        end else begin
            n_div = DIV_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= DIV_RESET;
        end else if (i_cfg_valid) begin
            r_div <= n_div;
        end
    end

    // capture and position multiply
    assign n_s2_prod = PROD_W'(r_s1_oidx) * PROD_W'(LAST_IDX);

    always_ff @(posedge i_clk) begin
        r_s1_req  <= i_req_type;
        r_s1_sidx <= i_sample_index;
        r_s1_sval <= i_sample_value;
        r_s1_oidx <= i_out_index;
        r_s2_req  <= r_s1_req;
        r_s2_sidx <= r_s1_sidx;
        r_s2_sval <= r_s1_sval;
        r_s2_oidx <= r_s1_oidx;
        r_s2_prod <= n_s2_prod;
    end

    // range check and divider
    assign w_num = {r_s2_prod, {FRAC_W{1'b0}}};
    assign w_hi  = w_num[NUM_W-1:QW];
    assign w_sat = (w_hi >= r_div);

    always_comb begin
        n_dv[0].req  = r_s2_req;
        n_dv[0].sidx = r_s2_sidx;
        n_dv[0].sval = r_s2_sval;
        n_dv[0].oidx = r_s2_oidx;
        n_dv[0].sat  = w_sat;
        n_dv[0].rem  = w_sat ? '0 : DIV_W'(w_hi);
        n_dv[0].q    = '0;
        n_dv[0].nlo  = w_num[QW-1:0];
        for (int k = 1; k < DV_STAGES; k++) begin
            n_dv[k] = dv_step(r_dv[k-1], r_div);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DV_STAGES; k++) begin
            r_dv[k] <= n_dv[k];
        end
    end

    // frame read and load write
    assign w_m     = r_dv[DV_STAGES-1];
    assign w_qint  = w_m.q[QW-1:FRAC_W];
    assign w_clamp = w_m.sat || (w_qint >= LAST_IDX);
    assign w_idx   = w_clamp ? LAST_IDX : IDX_W'(w_qint);
    assign w_nidx  = w_clamp ? LAST_IDX : w_idx + IDX_W'(1);
    assign w_frac  = w_clamp ? '0 : w_m.q[FRAC_W-1:0];
    assign w_waddr = IDX_W'(w_m.sidx);
    assign w_wr    = r_dv_vld[DV_STAGES-1] && (w_m.req == REQ_LOAD)
                     && (32'(w_m.sidx) < IN_SAMPLES);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_frame[w_waddr] <= w_m.sval;
        end
        r_m_s0 <= r_frame[w_idx];
        r_m_s1 <= r_frame[w_nidx];
    end

    always_ff @(posedge i_clk) begin
        r_m_frac <= w_frac;
        r_m_oidx <= w_m.oidx;
    end

    // interpolation
    assign w_diff = $signed({r_m_s1[SVAL_W-1], r_m_s1}) - $signed({r_m_s0[SVAL_W-1], r_m_s0});
    assign w_prod = w_diff * $signed({1'b0, r_m_frac});

    always_ff @(posedge i_clk) begin
        r_i_s0   <= r_m_s0;
        r_i_term <= w_prod[17:8];
        r_i_oidx <= r_m_oidx;
    end

    // gain and saturation
    assign w_mixed  = $signed({{3{r_i_s0[SVAL_W-1]}}, r_i_s0})
                      + $signed({r_i_term[9], r_i_term});
    assign w_scaled = w_mixed * GAIN;

    always_comb begin
        if (w_scaled > SAT_MAX) begin
            w_sample = OUT_W'(SAT_MAX);
        end else if (w_scaled < SAT_MIN) begin
            w_sample = OUT_W'(SAT_MIN);
        end else begin
            w_sample = w_scaled[OUT_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            for (int k = 0; k < DV_STAGES; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
            r_m_vld  <= 1'b0;
            r_i_vld  <= 1'b0;
        end else begin
            r_s1_vld    <= w_in_acc;
            r_s2_vld    <= r_s1_vld;
            r_dv_vld[0] <= r_s2_vld;
            for (int k = 1; k < DV_STAGES; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
            r_m_vld  <= r_dv_vld[DV_STAGES-1] && (w_m.req == REQ_OUTPUT);
            r_i_vld  <= r_m_vld;
        end
    end

    // output queue, pointers wrap at a power-of-two depth
    assign n_fifo_cnt = r_fifo_cnt + CNT_W'(r_i_vld) - CNT_W'(w_out_acc);
    assign n_credit   = r_credit + CNT_W'(w_req_acc) - CNT_W'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (r_i_vld) begin
            r_fifo_smp[r_wr_ptr] <= w_sample;
            r_fifo_pos[r_wr_ptr] <= r_i_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_credit   <= '0;
        end else begin
            if (r_i_vld) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_out_acc) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fifo_cnt <= n_fifo_cnt;
            r_credit   <= n_credit;
        end
    end

    assign o_out_valid    = (r_fifo_cnt != '0);
    assign o_out_sample   = $signed(r_fifo_smp[r_rd_ptr]);
    assign o_out_position = r_fifo_pos[r_rd_ptr];

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CNT_W'(FIFO_DEPTH))
        else $error("request credit above queue depth");

    a_queue_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= r_credit)
        else $error("queued results exceed requests in flight");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i_vld |-> (r_fifo_cnt != CNT_W'(FIFO_DEPTH)) || i_out_ready)
        else $error("result written into a full queue");

endmodule

`default_nettype wire
